// File: rtl/core/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg: shared types and constants for the sorted keyed table
// Holds the table size, the record layout, the action and status codes and
// the command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package skt_pkg;

  // Table size and the widths derived from it.
  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Operation codes carried by an input transaction.
  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_DUMP   = 2'd2
  } action_t;

  // Status codes carried by an output transaction.
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NOTFOUND = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_EMPTY    = 2'd3
  } status_t;

  // One stored record.
  typedef struct packed {
    logic signed [31:0] key;
    logic signed [31:0] node;
    logic [63:0]        name_w0;
    logic [63:0]        name_w1;
    logic [63:0]        name_w2;
    logic [47:0]        name_w3;
  } rec_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_INS_READ,
    ST_INS_STEP,
    ST_INS_LAST,
    ST_DEL_READ,
    ST_DEL_STEP,
    ST_DMP_READ,
    ST_DMP_EMIT,
    ST_RESULT
  } state_t;

  // Pointer update.
  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_TOP,
    PTR_ZERO,
    PTR_INC,
    PTR_DEC
  } ptr_op_t;

  // Read address choice relative to the pointer.
  typedef enum logic [1:0] {
    RD_PTR,
    RD_UP,
    RD_DOWN
  } rd_sel_t;

  // Write address and data choice.
  typedef enum logic [1:0] {
    WR_NEW_BASE,
    WR_NEW_ABOVE,
    WR_OLD_ABOVE,
    WR_OLD_BELOW
  } wr_sel_t;

  // Entry count update.
  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    ptr_op_t ptr_op;
    logic    found_clr;
    logic    found_set;
    cnt_op_t cnt_op;
    logic    out_load_rec;
    logic    out_load_status;
    logic    out_last;
    status_t status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] action;
    logic       cnt_zero;
    logic       cnt_full;
    logic       ptr_zero;
    logic       ptr_last;
    logic       key_gt;
    logic       key_eq;
    logic       found;
    logic       out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/core/sorted_keyed_table.sv
// ----------------------------------------------------------------------------
// sorted_keyed_table: ordered table of keyed records
// Keeps up to CAPACITY records in ascending signed key order, with insert,
// delete by key and an in-order dump.
//
// Channel  Handshake            Payload
// input    in_valid / in_stall  action, key, node, name_w0..name_w3
// output   out_valid / out_stall status, out_key, out_node,
//                               out_name_w0..out_name_w3, last
//
// Insert walks down from the top record; delete scans every stored record;
// dump reads each record in order and emits one per cycle unless stalled.
// Full and empty cases report without touching the memory. One record
// moves per cycle through the memory's single read and single write port.
// Reset clears the controller, entry count and output valid, not the memory.
// A stalled output holds its result; a new request is taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_keyed_table (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         action,
  input  wire logic signed [31:0] key,
  input  wire logic signed [31:0] node,
  input  wire logic [63:0]        name_w0,
  input  wire logic [63:0]        name_w1,
  input  wire logic [63:0]        name_w2,
  input  wire logic [47:0]        name_w3,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              status,
  output logic signed [31:0]      out_key,
  output logic signed [31:0]      out_node,
  output logic [63:0]             out_name_w0,
  output logic [63:0]             out_name_w1,
  output logic [63:0]             out_name_w2,
  output logic [47:0]             out_name_w3,
  output logic                    last
);

  import skt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  skt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Record memory and output register.
  skt_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .action      (action),
    .key         (key),
    .node        (node),
    .name_w0     (name_w0),
    .name_w1     (name_w1),
    .name_w2     (name_w2),
    .name_w3     (name_w3),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .out_key     (out_key),
    .out_node    (out_node),
    .out_name_w0 (out_name_w0),
    .out_name_w1 (out_name_w1),
    .out_name_w2 (out_name_w2),
    .out_name_w3 (out_name_w3),
    .last        (last)
  );

endmodule

`default_nettype wire

// File: rtl/core/skt_dp.sv
// ----------------------------------------------------------------------------
// skt_dp: datapath of the sorted keyed table
// Record memory with one write and one registered read port, the latched
// request, the scan pointer, the entry count and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_dp (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire skt_pkg::cmd_t       cmd,
  output skt_pkg::sts_t            sts,
  input  wire logic [1:0]          action,
  input  wire logic signed [31:0]  key,
  input  wire logic signed [31:0]  node,
  input  wire logic [63:0]         name_w0,
  input  wire logic [63:0]         name_w1,
  input  wire logic [63:0]         name_w2,
  input  wire logic [47:0]         name_w3,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [1:0]               status,
  output logic signed [31:0]       out_key,
  output logic signed [31:0]       out_node,
  output logic [63:0]              out_name_w0,
  output logic [63:0]              out_name_w1,
  output logic [63:0]              out_name_w2,
  output logic [47:0]              out_name_w3,
  output logic                     last
);

  import skt_pkg::*;

  rec_t             mem [CAPACITY];
  rec_t             in_rec;
  rec_t             rec_q;
  rec_t             rd_q;
  rec_t             wr_data;
  rec_t             out_rec;
  logic [1:0]       action_q;
  logic [IDX_W-1:0] ptr;
  logic [IDX_W-1:0] ptr_next;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic [CNT_W-1:0] count;
  logic             found;
  logic [1:0]       out_status;
  logic             out_last;

  // Incoming request as a record.
  assign in_rec = '{key: key, node: node, name_w0: name_w0, name_w1: name_w1,
                    name_w2: name_w2, name_w3: name_w3};

  // Latch the request when the transaction is taken.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rec_q    <= in_rec;
      action_q <= action;
    end
  end

  // Read and write addresses around the scan pointer.
  always_comb begin
    unique case (cmd.rd_sel)
      RD_PTR:  rd_addr = ptr;
      RD_UP:   rd_addr = ptr + IDX_W'(1);
      RD_DOWN: rd_addr = ptr - IDX_W'(1);
      default: rd_addr = ptr;
    endcase
    unique case (cmd.wr_sel)
      WR_NEW_BASE: begin
        wr_addr = '0;
        wr_data = rec_q;
      end
      WR_NEW_ABOVE: begin
        wr_addr = ptr + IDX_W'(1);
        wr_data = rec_q;
      end
      WR_OLD_ABOVE: begin
        wr_addr = ptr + IDX_W'(1);
        wr_data = rd_q;
      end
      default: begin
        wr_addr = ptr - IDX_W'(1);
        wr_data = rd_q;
      end
    endcase
  end

  // Record memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Scan pointer update.
  always_comb begin
    unique case (cmd.ptr_op)
      PTR_TOP:  ptr_next = IDX_W'(count - CNT_W'(1));
      PTR_ZERO: ptr_next = '0;
      PTR_INC:  ptr_next = ptr + IDX_W'(1);
      PTR_DEC:  ptr_next = ptr - IDX_W'(1);
      default:  ptr_next = ptr;
    endcase
  end

  // Pointer, entry count and match flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr   <= '0;
      count <= '0;
      found <= 1'b0;
    end else begin
      ptr <= ptr_next;
      unique case (cmd.cnt_op)
        CNT_INC: count <= count + CNT_W'(1);
        CNT_DEC: count <= count - CNT_W'(1);
        default: count <= count;
      endcase
      if (cmd.found_clr) begin
        found <= 1'b0;
      end else if (cmd.found_set) begin
        found <= 1'b1;
      end
    end
  end

  // Output register: valid flag with reset, payload without.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load_rec || cmd.out_load_status) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load_rec) begin
      out_rec    <= rd_q;
      out_status <= STAT_OK;
      out_last   <= cmd.out_last;
    end else if (cmd.out_load_status) begin
      out_rec    <= '0;
      out_status <= cmd.status;
      out_last   <= 1'b1;
    end
  end

  assign status      = out_status;
  assign out_key     = out_rec.key;
  assign out_node    = out_rec.node;
  assign out_name_w0 = out_rec.name_w0;
  assign out_name_w1 = out_rec.name_w1;
  assign out_name_w2 = out_rec.name_w2;
  assign out_name_w3 = out_rec.name_w3;
  assign last        = out_last;

  // Status towards the controller.
  assign sts.action   = action_q;
  assign sts.cnt_zero = (count == '0);
  assign sts.cnt_full = (count == CNT_W'(CAPACITY));
  assign sts.ptr_zero = (ptr == '0);
  assign sts.ptr_last = (CNT_W'(ptr) == count - CNT_W'(1));
  assign sts.key_gt   = (rec_q.key > rd_q.key);
  assign sts.key_eq   = (rec_q.key == rd_q.key);
  assign sts.found    = found;
  assign sts.out_free = !out_valid || !out_stall;

`ifndef SYNTH
  // A result is never loaded over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load_rec || cmd.out_load_status) |-> (!out_valid || !out_stall))
    else $error("output register overwritten while stalled");

  // Only entries that hold a record are read.
  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> (CNT_W'(rd_addr) < count))
    else $error("read beyond the stored records");

  // Writes stay within the stored records plus the slot being opened.
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> (CNT_W'(wr_addr) <= count))
    else $error("write beyond the stored records");

  // The count grows only below capacity and then by exactly one.
  a_count_grow: assert property (@(posedge clk) disable iff (rst)
    (cmd.cnt_op == CNT_INC) |-> (count < CNT_W'(CAPACITY)) ##1
    (count == $past(count) + CNT_W'(1)))
    else $error("entry count grew wrongly");
`endif

endmodule

`default_nettype wire

// File: rtl/core/skt_ctrl.sv
// ----------------------------------------------------------------------------
// skt_ctrl: controller of the sorted keyed table
// Sequences insert, delete and dump over the record memory and decides the
// status of each result.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire skt_pkg::sts_t  sts,
  output skt_pkg::cmd_t       cmd
);

  import skt_pkg::*;

  state_t  state;
  state_t  state_next;
  status_t res_code;
  status_t res_code_next;

  // State and result code registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      res_code <= STAT_OK;
    end else begin
      state    <= state_next;
      res_code <= res_code_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next    = state;
    res_code_next = res_code;
    in_stall      = 1'b1;
    cmd           = '0;
    cmd.rd_sel    = RD_PTR;
    cmd.wr_sel    = WR_NEW_BASE;
    cmd.ptr_op    = PTR_HOLD;
    cmd.cnt_op    = CNT_HOLD;
    cmd.status    = res_code;

    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DECODE;
        end
      end

      // Pick the operation from the latched request.
      ST_DECODE: begin
        unique case (sts.action)
          ACT_INSERT: begin
            if (sts.cnt_full) begin
              res_code_next = STAT_FULL;
              state_next    = ST_RESULT;
            end else if (sts.cnt_zero) begin
              state_next = ST_INS_LAST;
            end else begin
              cmd.ptr_op = PTR_TOP;
              state_next = ST_INS_READ;
            end
          end
          ACT_DELETE: begin
            if (sts.cnt_zero) begin
              res_code_next = STAT_EMPTY;
              state_next    = ST_RESULT;
            end else begin
              cmd.ptr_op    = PTR_ZERO;
              cmd.found_clr = 1'b1;
              state_next    = ST_DEL_READ;
            end
          end
          ACT_DUMP: begin
            if (sts.cnt_zero) begin
              res_code_next = STAT_EMPTY;
              state_next    = ST_RESULT;
            end else begin
              cmd.ptr_op = PTR_ZERO;
              state_next = ST_DMP_READ;
            end
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end

      // Insert: walk down from the top, moving each record not below the new key up.
      ST_INS_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = ST_INS_STEP;
      end

      ST_INS_STEP: begin
        cmd.wr_en = 1'b1;
        if (sts.key_gt) begin
          cmd.wr_sel    = WR_NEW_ABOVE;
          cmd.cnt_op    = CNT_INC;
          res_code_next = STAT_OK;
          state_next    = ST_RESULT;
        end else begin
          cmd.wr_sel = WR_OLD_ABOVE;
          if (sts.ptr_zero) begin
            state_next = ST_INS_LAST;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_DOWN;
            cmd.ptr_op = PTR_DEC;
          end
        end
      end

      ST_INS_LAST: begin
        cmd.wr_en     = 1'b1;
        cmd.wr_sel    = WR_NEW_BASE;
        cmd.cnt_op    = CNT_INC;
        res_code_next = STAT_OK;
        state_next    = ST_RESULT;
      end

      // Delete: walk up, and after the first match move each record down.
      ST_DEL_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = ST_DEL_STEP;
      end

      ST_DEL_STEP: begin
        if (sts.found) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WR_OLD_BELOW;
        end else if (sts.key_eq) begin
          cmd.found_set = 1'b1;
        end
        if (sts.ptr_last) begin
          if (sts.found || sts.key_eq) begin
            cmd.cnt_op    = CNT_DEC;
            res_code_next = STAT_OK;
          end else begin
            res_code_next = STAT_NOTFOUND;
          end
          state_next = ST_RESULT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_UP;
          cmd.ptr_op = PTR_INC;
        end
      end

      // Dump: one record per accepted output transaction.
      ST_DMP_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = ST_DMP_EMIT;
      end

      ST_DMP_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load_rec = 1'b1;
          cmd.out_last     = sts.ptr_last;
          if (sts.ptr_last) begin
            state_next = ST_IDLE;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_UP;
            cmd.ptr_op = PTR_INC;
          end
        end
      end

      // Single status result for insert and delete and the empty cases.
      ST_RESULT: begin
        if (sts.out_free) begin
          cmd.out_load_status = 1'b1;
          state_next          = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
